// ----- src/crp_pkg.sv -----
// Shared constants, state encoding and control bundles for the clock page replacement block.
`timescale 1ns / 1ps

package crp_pkg;

  localparam int MAX_CELLS   = 64;
  localparam int PAGE_COUNT  = 256;
  localparam int CELL_W      = $clog2(MAX_CELLS + 1);
  localparam int HAND_W      = $clog2(MAX_CELLS);
  localparam int PAGE_W      = $clog2(PAGE_COUNT);
  localparam int CFG_W       = 7;
  localparam int FAULT_W     = 32;
  localparam logic [CFG_W-1:0] CELLS_RESET = CFG_W'(MAX_CELLS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP,
    ST_EVICT,
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // latch request, start page table read
    logic mark_hit;   // set reference bit of resident page
    logic fill;       // take next free cell
    logic hand_norm;  // pull hand back into the managed range
    logic sweep_clr;  // clear reference bit under hand, advance
    logic evict_rd;   // pick victim cell under hand, read its page
    logic evict_clr;  // drop victim page from the page table
    logic load_new;   // write new page into its cell
    logic emit;       // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic can_fill;
    logic ref_set;
    logic out_free;
  } sts_t;

endpackage

// ----- src/crp_ctrl.sv -----
// Controller state machine for the clock page replacement block.
`timescale 1ns / 1ps

module crp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  crp_pkg::sts_t sts,
  output crp_pkg::cmd_t cmd
);
  import crp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.hit) begin
          cmd.mark_hit = 1'b1;
          state_nxt    = ST_EMIT;
        end else if (sts.can_fill) begin
          cmd.fill  = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          cmd.hand_norm = 1'b1;
          state_nxt     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sts.ref_set) begin
          cmd.sweep_clr = 1'b1;
        end else begin
          cmd.evict_rd = 1'b1;
          state_nxt    = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd.evict_clr = 1'b1;
        state_nxt     = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_new = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/crp_dp.sv -----
// Datapath of the clock page replacement block: tables, hand, counters, result register.
`timescale 1ns / 1ps

module crp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [crp_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [crp_pkg::PAGE_W-1:0]    in_page_id,
  input  crp_pkg::cmd_t                 cmd,
  output crp_pkg::sts_t                 sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [crp_pkg::CELL_W-1:0]    out_cell_res,
  output logic                          out_evicted_valid,
  output logic [crp_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [crp_pkg::FAULT_W-1:0]   out_fault_count
);
  import crp_pkg::*;

  logic [CFG_W-1:0]      cells_in_use_r;
  logic [CELL_W-1:0]     n_eff;
  logic [HAND_W-1:0]     hand_r;
  logic [CELL_W-1:0]     hand_p1;
  logic [HAND_W-1:0]     hand_adv;
  logic [CELL_W-1:0]     filled_r;
  logic [MAX_CELLS-1:0]  ref_r;
  logic [PAGE_W-1:0]     page_r;
  logic [CELL_W-1:0]     cell_r;
  logic [HAND_W-1:0]     cell_idx;
  logic [CELL_W-1:0]     hit_cell_m1;
  logic                  hit_r;
  logic                  ev_valid_r;
  logic [PAGE_W-1:0]     ev_page_r;
  logic [FAULT_W-1:0]    faults_r;

  logic [CELL_W-1:0]     p2c_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] p2c_vld_r;
  logic [CELL_W-1:0]     p2c_rd_r;
  logic                  p2c_hit_r;
  logic [PAGE_W-1:0]     cp_mem [MAX_CELLS];
  logic [PAGE_W-1:0]     cp_rd_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [CELL_W-1:0]     out_cell_r;
  logic                  out_ev_valid_r;
  logic [PAGE_W-1:0]     out_ev_page_r;
  logic [FAULT_W-1:0]    out_faults_r;

  // Clamp register value to 1..MAX_CELLS
  always_comb begin
    if (cells_in_use_r == '0) begin
      n_eff = CELL_W'(1);
    end else if (cells_in_use_r > CFG_W'(MAX_CELLS)) begin
      n_eff = CELL_W'(MAX_CELLS);
    end else begin
      n_eff = CELL_W'(cells_in_use_r);
    end
  end

  assign hand_p1     = CELL_W'(hand_r) + CELL_W'(1);
  assign hand_adv    = (hand_p1 >= n_eff) ? '0 : hand_p1[HAND_W-1:0];
  assign cell_idx    = HAND_W'(cell_r - CELL_W'(1));
  assign hit_cell_m1 = p2c_rd_r - CELL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_in_use_r <= CELLS_RESET;
    end else if (cfg_wr_en) begin
      cells_in_use_r <= cfg_wr_data;
    end
  end

  // Page table: data in RAM, residency in flops cleared at reset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p2c_rd_r  <= p2c_mem[in_page_id];
      p2c_hit_r <= p2c_vld_r[in_page_id];
    end
    if (cmd.load_new) begin
      p2c_mem[page_r] <= cell_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2c_vld_r <= '0;
    end else begin
      if (cmd.evict_clr) begin
        p2c_vld_r[cp_rd_r] <= 1'b0;
      end
      if (cmd.load_new) begin
        p2c_vld_r[page_r] <= 1'b1;
      end
    end
  end

  // Cell contents
  always_ff @(posedge clk) begin
    if (cmd.evict_rd) begin
      cp_rd_r <= cp_mem[hand_r];
    end
    if (cmd.load_new) begin
      cp_mem[cell_idx] <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= '0;
      hand_r   <= '0;
      filled_r <= '0;
      faults_r <= '0;
    end else begin
      if (cmd.mark_hit) begin
        ref_r[hit_cell_m1[HAND_W-1:0]] <= 1'b1;
      end
      if (cmd.sweep_clr) begin
        ref_r[hand_r] <= 1'b0;
      end
      if (cmd.load_new) begin
        ref_r[cell_idx] <= 1'b1;
      end
      if (cmd.hand_norm) begin
        if (CELL_W'(hand_r) >= n_eff) begin
          hand_r <= '0;
        end
      end else if (cmd.sweep_clr || cmd.evict_rd) begin
        hand_r <= hand_adv;
      end
      if (cmd.fill) begin
        filled_r <= filled_r + CELL_W'(1);
      end
      if (cmd.load_new && (faults_r != '1)) begin
        faults_r <= faults_r + FAULT_W'(1);
      end
    end
  end

  // Per-request working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r     <= in_page_id;
      hit_r      <= 1'b0;
      ev_valid_r <= 1'b0;
      ev_page_r  <= '0;
    end
    if (cmd.mark_hit) begin
      hit_r  <= 1'b1;
      cell_r <= p2c_rd_r;
    end
    if (cmd.fill) begin
      cell_r <= filled_r + CELL_W'(1);
    end
    if (cmd.evict_rd) begin
      cell_r <= hand_p1;
    end
    if (cmd.evict_clr) begin
      ev_valid_r <= 1'b1;
      ev_page_r  <= cp_rd_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit_r      <= hit_r;
      out_cell_r     <= cell_r;
      out_ev_valid_r <= ev_valid_r;
      out_ev_page_r  <= ev_page_r;
      out_faults_r   <= faults_r;
    end
  end

  assign sts.hit      = p2c_hit_r;
  assign sts.can_fill = (filled_r < n_eff);
  assign sts.ref_set  = ref_r[hand_r];
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_cell_res      = out_cell_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_faults_r;

  a_faults_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (faults_r >= $past(faults_r)))
    else $error("fault counter went backwards");

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CELL_W'(MAX_CELLS))
    else $error("more cells filled than exist");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && hit_r) |-> !ev_valid_r)
    else $error("hit reported an eviction");

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> ((cell_r != '0) && (cell_r <= CELL_W'(MAX_CELLS))))
    else $error("result cell out of range");

endmodule

// ----- src/clock_page_replacement_top.sv -----
// Top level of the clock (second-chance) page replacement block.
`timescale 1ns / 1ps
// Sequence: a hit goes from accept through decide to emit; a fill through decide, load, emit;
//   an eviction through decide, sweep (clearing set reference bits), evict, load and emit.
// Throughput: one request at a time; the next is taken once the current result is in the
//   output register, which may still be waiting on out_ready. The sweep loop sets the rate.
// Reset (rst_n low, synchronous): all pages not resident, reference bits and fill count
//   cleared, hand at the first cell, fault count zero, cells_in_use back to 64.
module clock_page_replacement_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [crp_pkg::CFG_W-1:0]     cfg_wr_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [crp_pkg::PAGE_W-1:0]    in_page_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [crp_pkg::CELL_W-1:0]    out_cell_res,
  output logic                          out_evicted_valid,
  output logic [crp_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [crp_pkg::FAULT_W-1:0]   out_fault_count
);
  import crp_pkg::*;

  // Command and status bundles between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // Controller: take each request through decide, sweep, evict and load as needed, then emit
  crp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: page table, cell table, reference bits, hand, counters and result register
  crp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_page_id        (in_page_id),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_cell_res      (out_cell_res),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the clock page replacement block: directed and random requests.
`timescale 1ns / 1ps

module tb;
  import crp_pkg::*;

  // One expected outcome of a page request, at the widths of the result ports.
  typedef struct packed {
    logic               hit;
    logic [CELL_W-1:0]  slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults;
  } page_result_t;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * MAX_CELLS + 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PAGE_W-1:0] in_page_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [CELL_W-1:0] out_cell_res;
  logic              out_evicted_valid;
  logic [PAGE_W-1:0] out_evicted_page;
  logic [FAULT_W-1:0] out_fault_count;

  // Page requests waiting for the driver, and outcomes waiting for the block.
  logic [PAGE_W-1:0] request_q[$];
  page_result_t      outcome_q[$];

  int errors = 0;
  int cycles = 0;
  int idle_odds = 0;   // one gap in idle_odds slots; 0 turns idling off
  int in_gap = 0;
  int out_gap = 0;

  // Shadow of the replacement state.
  int               page_slot[PAGE_COUNT];   // 0 means not resident
  logic [PAGE_W-1:0] slot_page[MAX_CELLS];
  bit               ref_bit[MAX_CELLS];
  int               filled;
  int               hand;
  logic [FAULT_W-1:0] fault_total;
  logic [CFG_W-1:0]  cells_cfg;

  clock_page_replacement_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_id        (in_page_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_cell_res      (out_cell_res),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

  always #10 clk = ~clk;

  // Clamp the programmed cell count to the range the block actually manages.
  function automatic int managed_cells(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_CELLS) return MAX_CELLS;
    return int'(v);
  endfunction

  // Apply one page request to the shadow state and return what the block must report.
  function automatic page_result_t replace_page(input logic [PAGE_W-1:0] page);
    page_result_t r;
    int n;
    int steps;
    int slot;
    logic [PAGE_W-1:0] victim;
    r = '0;
    n = managed_cells(cells_cfg);
    if (page_slot[page] != 0) begin
      // Hit: give the page its second chance back.
      r.hit = 1'b1;
      slot = page_slot[page];
      ref_bit[slot - 1] = 1'b1;
    end else begin
      if (filled < n) begin
        slot = filled + 1;
        filled = slot;
      end else begin
        // Pull the hand back in if the managed range shrank below it.
        if (hand >= n) hand = 0;
        steps = 0;
        while (ref_bit[hand] && steps <= n) begin
          ref_bit[hand] = 1'b0;
          hand = (hand + 1 >= n) ? 0 : hand + 1;
          steps++;
        end
        victim = slot_page[hand];
        page_slot[victim] = 0;
        r.ev_valid = 1'b1;
        r.ev_page = victim;
        slot = hand + 1;
        hand = (hand + 1 >= n) ? 0 : hand + 1;
      end
      slot_page[slot - 1] = page;
      ref_bit[slot - 1] = 1'b1;
      page_slot[page] = slot;
      if (fault_total != '1) fault_total++;
    end
    r.slot = CELL_W'(slot);
    r.faults = fault_total;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [FAULT_W-1:0] exp_v,
                                      input logic [FAULT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
      errors++;
    end
  endfunction

  // Request driver: predict on every accepted request, then load the next one
  // unless an idle burst is running.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        outcome_q.push_back(replace_page(in_page_id));
      end
      if (!in_valid || in_ready) begin
        if (idle_odds > 0 && in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_valid <= 1'b1;
          in_page_id <= request_q.pop_front();
          if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
            in_gap = $urandom_range(1, 16);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest outcome and
  // stall the result channel in random bursts.
  always @(posedge clk) begin
    page_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = outcome_q.pop_front();
          check_field("hit", FAULT_W'(want.hit), FAULT_W'(out_hit));
          check_field("cell_res", FAULT_W'(want.slot), FAULT_W'(out_cell_res));
          check_field("evicted_valid", FAULT_W'(want.ev_valid), FAULT_W'(out_evicted_valid));
          // Without a replacement the evicted page reads as zero.
          check_field("evicted_page", FAULT_W'(want.ev_page), FAULT_W'(out_evicted_page));
          check_field("fault_count", want.faults, out_fault_count);
        end
      end
      if (idle_odds > 0 && out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
          out_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Wait until every request has gone through and every result has come back.
  task automatic settle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Program the cell count; only called while the block is idle.
  task automatic write_cells(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cells_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random phase: mostly a working set a bit larger than the managed cells, so
  // hits, fills and sweeps all show up; the rest spread over every page.
  task automatic run_phase(input logic [CFG_W-1:0] cells, input int count, input int odds);
    int span;
    int base;
    int i;
    settle();
    write_cells(cells);
    idle_odds = odds;
    span = managed_cells(cells) + managed_cells(cells) / 2 + 1;
    base = $urandom_range(0, PAGE_COUNT - 1);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        request_q.push_back(PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
      end else begin
        request_q.push_back(PAGE_W'(base + $urandom_range(0, span)));
      end
    end
  endtask

  initial begin
    int i;
    logic [PAGE_W-1:0] directed[$];

    // Clear the shadow state the same way reset clears the block.
    for (i = 0; i < PAGE_COUNT; i++) page_slot[i] = 0;
    for (i = 0; i < MAX_CELLS; i++) begin
      ref_bit[i] = 1'b0;
      slot_page[i] = '0;
    end
    filled = 0;
    hand = 0;
    fault_total = '0;
    cells_cfg = CELLS_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: three cells; page 0 and the extreme pages, a hit, then misses
    // with every reference bit set so the hand sweeps a full turn.
    idle_odds = 6;
    write_cells(CFG_W'(3));
    directed = '{8'd0, 8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd127, 8'd85, 8'd170, 8'd1};
    foreach (directed[k]) request_q.push_back(directed[k]);
    settle();

    // Count of zero acts as one cell; cells two and three keep their pages,
    // which must still hit, and the hand restarts at the first cell.
    write_cells('0);
    directed = '{8'd7, 8'd7, 8'd9, 8'd170, 8'd85, 8'd0};
    foreach (directed[k]) request_q.push_back(directed[k]);
    settle();

    // All ones acts as the maximum: filling resumes after cell three.
    write_cells('1);
    directed = '{8'd200, 8'd201, 8'd202, 8'd85, 8'd9};
    foreach (directed[k]) request_q.push_back(directed[k]);

    // Random phases over a spread of cell counts, extremes included.
    run_phase(CFG_W'(64), 110, 5);
    run_phase(CFG_W'(1), 100, 8);
    run_phase(CFG_W'(5), 100, 3);
    run_phase(CFG_W'($urandom_range(1, 64)), 100, 10);
    run_phase(CFG_W'(16), 100, 4);
    run_phase('1, 110, 12);
    run_phase('0, 90, 6);
    run_phase(CFG_W'($urandom_range(0, 127)), 100, 5);
    run_phase(CFG_W'(33), 100, 7);
    // Last stretch runs back to back on both sides.
    run_phase(CFG_W'(64), 140, 0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- clock_page_replacement_top.f -----
src/crp_pkg.sv
src/crp_ctrl.sv
src/crp_dp.sv
src/clock_page_replacement_top.sv
verif/tb.sv
